[rtl/core/qcco_pkg.sv]
// ----------------------------------------------------------------------------
// qcco_pkg
// shared constants, the angle class code and the class function for the
// quad corner ordering block
// ----------------------------------------------------------------------------
package qcco_pkg;

    // default coordinate width, unsigned Q12.4
    localparam int COORD_BITS_DEF = 16;

    // a quad always has four corners
    localparam int NCORNERS       = 4;
    localparam int CORNER_IDX_W   = $clog2(NCORNERS);

    // half-plane class of a centroid offset, in ascending angle order
    typedef enum logic [1:0] {
        AC_NEG  = 2'd0,  // angle in (-pi, 0)
        AC_ZERO = 2'd1,  // angle 0, and the zero offset
        AC_POS  = 2'd2,  // angle in (0, pi)
        AC_PI   = 2'd3   // negative x axis
    } t_aclass;

    // class from the sign and zero flags of an offset
    function automatic t_aclass angle_class(input logic y_neg, input logic y_zero,
                                            input logic x_neg);
        t_aclass c;
        if (y_neg) begin
            c = AC_NEG;
        end else if (!y_zero) begin
            c = AC_POS;
        end else if (x_neg) begin
            c = AC_PI;
        end else begin
            c = AC_ZERO;
        end
        return c;
    endfunction

endpackage

[rtl/core/qcco_if.sv]
// ----------------------------------------------------------------------------
// qcco_if
// valid/ready channels for quad corners in and ordered corners out
// ----------------------------------------------------------------------------
interface qcco_in_if #(
    parameter int COORD_BITS = qcco_pkg::COORD_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] in_x0;
    logic [COORD_BITS-1:0] in_y0;
    logic [COORD_BITS-1:0] in_x1;
    logic [COORD_BITS-1:0] in_y1;
    logic [COORD_BITS-1:0] in_x2;
    logic [COORD_BITS-1:0] in_y2;
    logic [COORD_BITS-1:0] in_x3;
    logic [COORD_BITS-1:0] in_y3;

    modport source (
        output valid, in_x0, in_y0, in_x1, in_y1, in_x2, in_y2, in_x3, in_y3,
        input  ready
    );
    modport sink (
        input  valid, in_x0, in_y0, in_x1, in_y1, in_x2, in_y2, in_x3, in_y3,
        output ready
    );
endinterface

interface qcco_out_if #(
    parameter int COORD_BITS = qcco_pkg::COORD_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] out_x0;
    logic [COORD_BITS-1:0] out_y0;
    logic [COORD_BITS-1:0] out_x1;
    logic [COORD_BITS-1:0] out_y1;
    logic [COORD_BITS-1:0] out_x2;
    logic [COORD_BITS-1:0] out_y2;
    logic [COORD_BITS-1:0] out_x3;
    logic [COORD_BITS-1:0] out_y3;

    modport source (
        output valid, out_x0, out_y0, out_x1, out_y1, out_x2, out_y2, out_x3, out_y3,
        input  ready
    );
    modport sink (
        input  valid, out_x0, out_y0, out_x1, out_y1, out_x2, out_y2, out_x3, out_y3,
        output ready
    );
endinterface

[rtl/core/qcco_angle_pair.sv]
// ----------------------------------------------------------------------------
// qcco_angle_pair
// one pipeline stage that compares the angles of two centroid offsets:
// registered cross products and classes, compare decoded after the register
// ----------------------------------------------------------------------------
module qcco_angle_pair #(
    parameter int DW = qcco_pkg::COORD_BITS_DEF + 3
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [DW-1:0] i_ax,
    input  logic signed [DW-1:0] i_ay,
    input  logic signed [DW-1:0] i_bx,
    input  logic signed [DW-1:0] i_by,
    output logic                 o_a_lt_b,
    output logic                 o_b_lt_a
);
    import qcco_pkg::*;

    localparam int PW = 2 * DW;

    logic signed [PW-1:0] r_p_axby;
    logic signed [PW-1:0] r_p_aybx;
    t_aclass              r_ca;
    t_aclass              r_cb;
    logic signed [PW:0]   w_cross;
    logic                 w_open;

    // products and classes
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_axby <= i_ax * i_by;
            r_p_aybx <= i_ay * i_bx;
            r_ca     <= angle_class(i_ay[DW-1], i_ay == '0, i_ax[DW-1]);
            r_cb     <= angle_class(i_by[DW-1], i_by == '0, i_bx[DW-1]);
        end
    end

    // cross product sign decides inside the same open half-plane
    assign w_cross = {r_p_axby[PW-1], r_p_axby} - {r_p_aybx[PW-1], r_p_aybx};
    assign w_open  = (r_ca == r_cb) && ((r_ca == AC_NEG) || (r_ca == AC_POS));

    assign o_a_lt_b = (r_ca < r_cb) || (w_open && !w_cross[PW] && (w_cross != '0));
    assign o_b_lt_a = (r_cb < r_ca) || (w_open && w_cross[PW]);

endmodule

[rtl/core/quad_corner_clockwise_order.sv]
// ----------------------------------------------------------------------------
// quad_corner_clockwise_order
// orders the four corners of a quad by angle around the centroid and rotates
// the list so the corner with the smallest x+y leads
// ----------------------------------------------------------------------------
// The block takes one quad word per cycle and gives one ordered word per cycle
// while the output does not stall. The seven register stages are: input,
// coordinate sums, centroid offsets, the twelve cross product multipliers,
// angle ranks, sorted corners, and the rotated output register. Each stage has
// its own valid bit and loads whenever it is empty or the next stage moves, so a
// stall on the output fills the empty stages behind it before ready drops.
// ----------------------------------------------------------------------------
module quad_corner_clockwise_order #(
    parameter int COORD_BITS = qcco_pkg::COORD_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    qcco_in_if.sink        i_in,
    qcco_out_if.source     o_out
);
    import qcco_pkg::*;

    localparam int CW   = COORD_BITS;
    localparam int SW   = CW + 2;   // sum of four coordinates
    localparam int DW   = CW + 3;   // signed centroid offset
    localparam int PSW  = CW + 1;   // x+y of one corner
    localparam int NC   = NCORNERS;
    localparam int CIW  = CORNER_IDX_W;
    localparam int NSTG = 7;

    typedef logic [CW-1:0]         t_coord;
    typedef logic [SW-1:0]         t_csum;
    typedef logic signed [DW-1:0]  t_offs;
    typedef logic [PSW-1:0]        t_psum;
    typedef logic [CIW-1:0]        t_idx;

    // stage handshake
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] w_en;

    // stage data
    t_coord w_in_x   [NC];
    t_coord w_in_y   [NC];
    t_coord r_s0_x   [NC];
    t_coord r_s0_y   [NC];
    t_coord r_s1_x   [NC];
    t_coord r_s1_y   [NC];
    t_csum  r_s1_sx;
    t_csum  r_s1_sy;
    t_coord r_s2_x   [NC];
    t_coord r_s2_y   [NC];
    t_offs  r_s2_dx  [NC];
    t_offs  r_s2_dy  [NC];
    t_coord r_s3_x   [NC];
    t_coord r_s3_y   [NC];
    wire    [NC-1:0] w_lt [NC];
    t_idx   w_rank   [NC];
    t_idx   r_s4_rank[NC];
    t_coord r_s4_x   [NC];
    t_coord r_s4_y   [NC];
    t_psum  r_s4_sum [NC];
    t_coord r_s5_x   [NC];
    t_coord r_s5_y   [NC];
    t_psum  r_s5_sum [NC];
    t_idx   w_lead;
    t_coord r_s6_x   [NC];
    t_coord r_s6_y   [NC];

    // input word unpack
    assign w_in_x[0] = i_in.in_x0;
    assign w_in_y[0] = i_in.in_y0;
    assign w_in_x[1] = i_in.in_x1;
    assign w_in_y[1] = i_in.in_y1;
    assign w_in_x[2] = i_in.in_x2;
    assign w_in_y[2] = i_in.in_y2;
    assign w_in_x[3] = i_in.in_x3;
    assign w_in_y[3] = i_in.in_y3;

    // stage load enables, from the output back to the input
    always_comb begin
        w_en[NSTG-1] = !r_vld[NSTG-1] || o_out.ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign i_in.ready = w_en[0];

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_in.valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // stage 0: input register
    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_s0_x <= w_in_x;
            r_s0_y <= w_in_y;
        end
    end

    // stage 1: coordinate sums
    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_s1_x  <= r_s0_x;
            r_s1_y  <= r_s0_y;
            r_s1_sx <= SW'(r_s0_x[0]) + SW'(r_s0_x[1]) + SW'(r_s0_x[2]) + SW'(r_s0_x[3]);
            r_s1_sy <= SW'(r_s0_y[0]) + SW'(r_s0_y[1]) + SW'(r_s0_y[2]) + SW'(r_s0_y[3]);
        end
    end

    // stage 2: offsets 4*p - sum, exact
    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r_s2_x <= r_s1_x;
            r_s2_y <= r_s1_y;
            for (int i = 0; i < NC; i++) begin
                r_s2_dx[i] <= $signed({1'b0, r_s1_x[i], 2'b00}) - $signed({1'b0, r_s1_sx});
                r_s2_dy[i] <= $signed({1'b0, r_s1_y[i], 2'b00}) - $signed({1'b0, r_s1_sy});
            end
        end
    end

    // stage 3: pairwise angle compares
    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r_s3_x <= r_s2_x;
            r_s3_y <= r_s2_y;
        end
    end

    for (genvar gi = 0; gi < NC; gi++) begin : g_row
        assign w_lt[gi][gi] = 1'b0;
        for (genvar gj = gi + 1; gj < NC; gj++) begin : g_col
            qcco_angle_pair #(
                .DW (DW)
            ) u_pair (
                .i_clk    (i_clk),
                .i_en     (w_en[3]),
                .i_ax     (r_s2_dx[gi]),
                .i_ay     (r_s2_dy[gi]),
                .i_bx     (r_s2_dx[gj]),
                .i_by     (r_s2_dy[gj]),
                .o_a_lt_b (w_lt[gi][gj]),
                .o_b_lt_a (w_lt[gj][gi])
            );
        end
    end

    // stable rank: corners that sort before, ties to the lower index
    always_comb begin
        for (int i = 0; i < NC; i++) begin
            w_rank[i] = '0;
            for (int j = 0; j < NC; j++) begin
                if ((j != i) && (w_lt[j][i] || (!w_lt[i][j] && (j < i)))) begin
                    w_rank[i] = w_rank[i] + t_idx'(1);
                end
            end
        end
    end

    // stage 4: ranks and per corner x+y
    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r_s4_rank <= w_rank;
            r_s4_x    <= r_s3_x;
            r_s4_y    <= r_s3_y;
            for (int i = 0; i < NC; i++) begin
                r_s4_sum[i] <= PSW'(r_s3_x[i]) + PSW'(r_s3_y[i]);
            end
        end
    end

    // stage 5: corners placed in sorted order
    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            for (int k = 0; k < NC; k++) begin
                for (int i = 0; i < NC; i++) begin
                    if (r_s4_rank[i] == t_idx'(k)) begin
                        r_s5_x[k]   <= r_s4_x[i];
                        r_s5_y[k]   <= r_s4_y[i];
                        r_s5_sum[k] <= r_s4_sum[i];
                    end
                end
            end
        end
    end

    // first smallest x+y in sorted order
    always_comb begin
        t_psum best;
        best   = r_s5_sum[0];
        w_lead = '0;
        for (int i = 1; i < NC; i++) begin
            if (r_s5_sum[i] < best) begin
                best   = r_s5_sum[i];
                w_lead = t_idx'(i);
            end
        end
    end

    // stage 6: rotated output register
    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            for (int k = 0; k < NC; k++) begin
                r_s6_x[k] <= r_s5_x[t_idx'(w_lead + t_idx'(k))];
                r_s6_y[k] <= r_s5_y[t_idx'(w_lead + t_idx'(k))];
            end
        end
    end

    // output word
    assign o_out.valid  = r_vld[NSTG-1];
    assign o_out.out_x0 = r_s6_x[0];
    assign o_out.out_y0 = r_s6_y[0];
    assign o_out.out_x1 = r_s6_x[1];
    assign o_out.out_y1 = r_s6_y[1];
    assign o_out.out_x2 = r_s6_x[2];
    assign o_out.out_y2 = r_s6_y[2];
    assign o_out.out_x3 = r_s6_x[3];
    assign o_out.out_y3 = r_s6_y[3];

endmodule

[rtl/core/qcco_checker.sv]
// ----------------------------------------------------------------------------
// qcco_checker
// port level checks of the quad corner ordering block, bound to the top level
// ----------------------------------------------------------------------------
module qcco_checker #(
    parameter int COORD_BITS = qcco_pkg::COORD_BITS_DEF
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_ready,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input logic [COORD_BITS-1:0] i_x0,
    input logic [COORD_BITS-1:0] i_y0,
    input logic [COORD_BITS-1:0] i_x1,
    input logic [COORD_BITS-1:0] i_y1,
    input logic [COORD_BITS-1:0] i_x2,
    input logic [COORD_BITS-1:0] i_y2,
    input logic [COORD_BITS-1:0] i_x3,
    input logic [COORD_BITS-1:0] i_y3
);
    localparam int PSW = COORD_BITS + 1;

    logic [PSW-1:0] w_s0;
    logic [PSW-1:0] w_s1;
    logic [PSW-1:0] w_s2;
    logic [PSW-1:0] w_s3;

    assign w_s0 = PSW'(i_x0) + PSW'(i_y0);
    assign w_s1 = PSW'(i_x1) + PSW'(i_y1);
    assign w_s2 = PSW'(i_x2) + PSW'(i_y2);
    assign w_s3 = PSW'(i_x3) + PSW'(i_y3);

    // a stalled output word holds its corners
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable({i_x0, i_y0, i_x1,
            i_y1, i_x2, i_y2, i_x3, i_y3})))
        else $error("output word changed while stalled");

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // an empty or draining output stage lets the input move
    a_ready_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_out_valid || i_out_ready) |-> i_in_ready)
        else $error("input stalled while output stage can move");

    // the leading corner has the smallest x+y
    a_lead_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((w_s0 <= w_s1) && (w_s0 <= w_s2) && (w_s0 <= w_s3)))
        else $error("leading corner does not have the smallest x+y");

endmodule

bind quad_corner_clockwise_order qcco_checker #(
    .COORD_BITS (COORD_BITS)
) u_qcco_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_x0        (o_out.out_x0),
    .i_y0        (o_out.out_y0),
    .i_x1        (o_out.out_x1),
    .i_y1        (o_out.out_y1),
    .i_x2        (o_out.out_x2),
    .i_y2        (o_out.out_y2),
    .i_x3        (o_out.out_x3),
    .i_y3        (o_out.out_y3)
);

[verif/quad_corner_clockwise_order_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quad_corner_clockwise_order_test
// self-checking bench for the quad corner ordering block: a table of directed
// quads, then random quads of several shapes, with random gaps on both
// channels and one long output hold-off. Every ordered word is compared field
// by field with a known row's typed-in answer or the word the bench's sorter predicts.
// ----------------------------------------------------------------------------
module quad_corner_clockwise_order_test;

    import qcco_pkg::*;

    localparam int CB              = COORD_BITS_DEF;
    localparam int RANDOM_QUADS    = 940;
    localparam int IDLE_LIMIT      = 2000;
    localparam int DRAIN_CYCLES    = 20;
    localparam int PRESSURE_AT     = 250;
    localparam int PRESSURE_CYCLES = 200;
    localparam int CALM_LO         = 500;
    localparam int CALM_HI         = 600;

    typedef logic [NCORNERS-1:0][CB-1:0] t_corner_set;

    // one quad word: corner k is (x[k], y[k])
    typedef struct packed {
        t_corner_set x;
        t_corner_set y;
    } t_quad;

    // one directed row; known rows carry a typed-in answer
    typedef struct packed {
        t_quad stim;
        logic  known;
        t_quad want;
    } t_quad_row;

    logic i_clk;
    logic i_rst_n;

    qcco_in_if  #(.COORD_BITS(CB)) in_if ();
    qcco_out_if #(.COORD_BITS(CB)) out_if ();

    quad_corner_clockwise_order #(
        .COORD_BITS(CB)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_quad     ordered_q [$];
    t_quad_row quad_rows [$];
    int        mismatch_count = 0;
    int        quads_sent     = 0;
    int        words_checked  = 0;
    int        input_stalls   = 0;
    int        longest_hold   = 0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- predictor

    // half-plane class of a centroid offset
    function automatic t_aclass offset_class(input longint dx, input longint dy);
        if (dy < 0) return AC_NEG;
        if (dy > 0) return AC_POS;
        if (dx < 0) return AC_PI;
        return AC_ZERO;
    endfunction

    // strict angle order of two offsets, by class then by cross product
    function automatic bit angle_before(input longint ax, input longint ay,
                                        input longint bx, input longint by);
        t_aclass ca;
        t_aclass cb;
        ca = offset_class(ax, ay);
        cb = offset_class(bx, by);
        if (ca != cb) return ca < cb;
        if (ca == AC_ZERO || ca == AC_PI) return 1'b0;
        return (ax * by - ay * bx) > 0;
    endfunction

    // sort corners by angle around the centroid, then rotate to the min x+y corner
    function automatic t_quad order_corners(input t_quad q);
        longint sx;
        longint sy;
        longint dx [NCORNERS];
        longint dy [NCORNERS];
        longint best;
        longint s;
        int     rank [NCORNERS];
        int     cur;
        int     j;
        int     lead;
        int     k;
        t_quad  r;
        sx = 0;
        sy = 0;
        for (int i = 0; i < NCORNERS; i++) begin
            sx += longint'(q.x[i]);
            sy += longint'(q.y[i]);
        end
        for (int i = 0; i < NCORNERS; i++) begin
            dx[i]   = 4 * longint'(q.x[i]) - sx;
            dy[i]   = 4 * longint'(q.y[i]) - sy;
            rank[i] = i;
        end
        // stable insertion sort, equal angles keep input order
        for (int i = 1; i < NCORNERS; i++) begin
            cur = rank[i];
            j   = i - 1;
            while (j >= 0 && angle_before(dx[cur], dy[cur], dx[rank[j]], dy[rank[j]])) begin
                rank[j + 1] = rank[j];
                j--;
            end
            rank[j + 1] = cur;
        end
        // earliest corner with the smallest x+y leads
        lead = 0;
        best = longint'(q.x[rank[0]]) + longint'(q.y[rank[0]]);
        for (int i = 1; i < NCORNERS; i++) begin
            s = longint'(q.x[rank[i]]) + longint'(q.y[rank[i]]);
            if (s < best) begin
                best = s;
                lead = i;
            end
        end
        for (int i = 0; i < NCORNERS; i++) begin
            k      = rank[(lead + i) % NCORNERS];
            r.x[i] = q.x[k];
            r.y[i] = q.y[k];
        end
        return r;
    endfunction

    // ---------------------------------------------------------------- stimulus

    function automatic t_quad make_quad(input int x0, input int y0, input int x1, input int y1,
                                        input int x2, input int y2, input int x3, input int y3);
        t_quad q;
        q.x[0] = x0[CB-1:0];
        q.y[0] = y0[CB-1:0];
        q.x[1] = x1[CB-1:0];
        q.y[1] = y1[CB-1:0];
        q.x[2] = x2[CB-1:0];
        q.y[2] = y2[CB-1:0];
        q.x[3] = x3[CB-1:0];
        q.y[3] = y3[CB-1:0];
        return q;
    endfunction

    // append one directed row to the table
    task automatic add_row(input t_quad stim, input logic known, input t_quad want);
        t_quad_row row;
        row.stim  = stim;
        row.known = known;
        row.want  = want;
        quad_rows = {quad_rows, row};
    endtask

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    // coordinate near the edges of the range
    function automatic logic [CB-1:0] edge_coord();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return CB'(1);
            2: return {CB{1'b1}} - 1'b1;
            3: return {CB{1'b1}};
            4: return {1'b1, {(CB-1){1'b0}}};
            default: return CB'($urandom());
        endcase
    endfunction

    // random quad: full range, one corner per quadrant, tiny grids, repeats, edge values
    function automatic t_quad random_quad();
        t_quad         q;
        int            kind;
        int            cx;
        int            cy;
        int            j;
        logic [CB-1:0] t;
        kind = $urandom_range(0, 99);
        for (int i = 0; i < NCORNERS; i++) begin
            q.x[i] = CB'($urandom());
            q.y[i] = CB'($urandom());
        end
        if (kind >= 35 && kind < 65) begin
            // one corner in each quadrant around a random center
            cx = $urandom_range(8192, 57343);
            cy = $urandom_range(8192, 57343);
            q  = make_quad(cx - $urandom_range(1, 8000), cy - $urandom_range(1, 8000),
                           cx + $urandom_range(1, 8000), cy - $urandom_range(1, 8000),
                           cx + $urandom_range(1, 8000), cy + $urandom_range(1, 8000),
                           cx - $urandom_range(1, 8000), cy + $urandom_range(1, 8000));
        end else if (kind >= 65 && kind < 80) begin
            // tiny grid: many ties, collinear sets and centroid hits
            for (int i = 0; i < NCORNERS; i++) begin
                q.x[i] = CB'($urandom_range(0, 7));
                q.y[i] = CB'($urandom_range(0, 7));
            end
        end else if (kind >= 80 && kind < 90) begin
            // repeated corners drawn from a pool of two
            for (int i = 0; i < NCORNERS; i++) begin
                j      = $urandom_range(0, 1);
                q.x[i] = q.x[j];
                q.y[i] = q.y[j];
            end
        end else if (kind >= 90) begin
            for (int i = 0; i < NCORNERS; i++) begin
                q.x[i] = edge_coord();
                q.y[i] = edge_coord();
            end
        end
        // shuffle the corner order
        for (int i = NCORNERS - 1; i > 0; i--) begin
            j      = $urandom_range(0, i);
            t      = q.x[i];
            q.x[i] = q.x[j];
            q.x[j] = t;
            t      = q.y[i];
            q.y[i] = q.y[j];
            q.y[j] = t;
        end
        return q;
    endfunction

    // offer one quad word after a gap, hold it until accepted
    task automatic send_quad(input t_quad q, input t_quad want);
        int gap;
        gap = (quads_sent >= CALM_LO && quads_sent < CALM_HI) ? 0 : pick_gap();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.in_x0 <= q.x[0];
        in_if.in_y0 <= q.y[0];
        in_if.in_x1 <= q.x[1];
        in_if.in_y1 <= q.y[1];
        in_if.in_x2 <= q.x[2];
        in_if.in_y2 <= q.y[2];
        in_if.in_x3 <= q.x[3];
        in_if.in_y3 <= q.y[3];
        do @(posedge i_clk); while (!in_if.ready);
        ordered_q = {ordered_q, want};
        quads_sent++;
    endtask

    task automatic report_mismatch(input string what, input int word_idx,
                                   input longint got, input longint want);
        $display("mismatch on word %0d, %s: got %0h want %0h", word_idx, what, got, want);
        mismatch_count++;
    endtask

    // ---------------------------------------------------------------- main flow

    initial begin
        t_quad_row row;
        t_quad     q;
        i_rst_n      = 1'b0;
        in_if.valid  = 1'b0;
        in_if.in_x0  = '0;
        in_if.in_y0  = '0;
        in_if.in_x1  = '0;
        in_if.in_y1  = '0;
        in_if.in_x2  = '0;
        in_if.in_y2  = '0;
        in_if.in_x3  = '0;
        in_if.in_y3  = '0;
        out_if.ready = 1'b0;

        // directed table: all zero, all max, squares, then the special cases
        add_row(make_quad(0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                make_quad(0, 0, 0, 0, 0, 0, 0, 0));
        add_row(make_quad(65535, 65535, 65535, 65535, 65535, 65535, 65535, 65535), 1'b1,
                make_quad(65535, 65535, 65535, 65535, 65535, 65535, 65535, 65535));
        add_row(make_quad(0, 0, 16, 0, 16, 16, 0, 16), 1'b1,
                make_quad(0, 0, 16, 0, 16, 16, 0, 16));
        add_row(make_quad(0, 0, 65535, 0, 65535, 65535, 0, 65535), 1'b1,
                make_quad(0, 0, 65535, 0, 65535, 65535, 0, 65535));
        // same squares with the corners fed in other orders
        q = make_quad(65535, 65535, 0, 65535, 0, 0, 65535, 0);
        add_row(q, 1'b0, q);
        q = make_quad(16, 16, 0, 0, 0, 16, 16, 0);
        add_row(q, 1'b0, q);
        q = make_quad(65535, 0, 0, 65535, 65535, 65535, 0, 0);
        add_row(q, 1'b0, q);
        // a corner sitting on the centroid
        q = make_quad(0, 0, 128, 0, 64, 192, 64, 64);
        add_row(q, 1'b0, q);
        // diamond with a corner on the negative x axis
        q = make_quad(0, 32, 32, 0, 64, 32, 32, 64);
        add_row(q, 1'b0, q);
        q = make_quad(64, 32, 32, 64, 0, 32, 32, 0);
        add_row(q, 1'b0, q);
        // collinear corners, equal angles
        q = make_quad(48, 48, 0, 0, 32, 32, 16, 16);
        add_row(q, 1'b0, q);
        q = make_quad(30, 5, 0, 5, 20, 5, 10, 5);
        add_row(q, 1'b0, q);
        q = make_quad(7, 40, 7, 0, 7, 30, 7, 10);
        add_row(q, 1'b0, q);
        // two corners share the smallest x+y
        q = make_quad(48, 32, 0, 16, 32, 48, 16, 0);
        add_row(q, 1'b0, q);
        // repeated corners
        q = make_quad(100, 7, 5, 5, 100, 7, 5, 5);
        add_row(q, 1'b0, q);
        q = make_quad(200, 300, 9, 9, 9, 9, 9, 9);
        add_row(q, 1'b0, q);
        // concave quad and alternating bit patterns
        q = make_quad(20, 20, 0, 100, 100, 0, 0, 0);
        add_row(q, 1'b0, q);
        q = make_quad(16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA, 16'hFFFF, 16'h0000,
                      16'h0000, 16'hFFFF);
        add_row(q, 1'b0, q);
        q = make_quad(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h0001, 16'hFFFE,
                      16'hFFFE, 16'h0001);
        add_row(q, 1'b0, q);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows
        foreach (quad_rows[n]) begin
            row = quad_rows[n];
            send_quad(row.stim, row.known ? row.want : order_corners(row.stim));
        end
        // random quads
        for (int n = 0; n < RANDOM_QUADS; n++) begin
            q = random_quad();
            send_quad(q, order_corners(q));
        end
        in_if.valid <= 1'b0;

        // drain, then look for stray words
        while (ordered_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("ran %0d directed and %0d random quads, %0d ordered words checked",
                 quad_rows.size(), quads_sent - quad_rows.size(), words_checked);
        $display("output held off up to %0d cycles, input stalled on %0d offered cycles",
                 longest_hold, input_stalls);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // ---------------------------------------------------------------- receiver

    // output ready pacing and word check
    initial begin
        int    stall_left;
        bit    pressure_done;
        t_quad got;
        t_quad want;
        stall_left    = 0;
        pressure_done = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            // compare an accepted word with the oldest prediction
            if (out_if.valid && out_if.ready) begin
                got.x[0] = out_if.out_x0;
                got.y[0] = out_if.out_y0;
                got.x[1] = out_if.out_x1;
                got.y[1] = out_if.out_y1;
                got.x[2] = out_if.out_x2;
                got.y[2] = out_if.out_y2;
                got.x[3] = out_if.out_x3;
                got.y[3] = out_if.out_y3;
                if (ordered_q.size() == 0) begin
                    report_mismatch("word with none expected", words_checked,
                                    longint'(got.x[0]), longint'(0));
                end else begin
                    want = ordered_q.pop_front();
                    for (int k = 0; k < NCORNERS; k++) begin
                        if (got.x[k] !== want.x[k])
                            report_mismatch($sformatf("out_x%0d", k), words_checked,
                                            longint'(got.x[k]), longint'(want.x[k]));
                        if (got.y[k] !== want.y[k])
                            report_mismatch($sformatf("out_y%0d", k), words_checked,
                                            longint'(got.y[k]), longint'(want.y[k]));
                    end
                end
                words_checked++;
            end
            // one long hold-off so the pipeline fills and stalls its input
            if (!pressure_done && words_checked == PRESSURE_AT) begin
                pressure_done = 1'b1;
                stall_left    = PRESSURE_CYCLES;
                if (PRESSURE_CYCLES > longest_hold) longest_hold = PRESSURE_CYCLES;
            end
            // next ready value
            if (stall_left > 0) begin
                stall_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
                if (!(words_checked >= CALM_LO && words_checked < CALM_HI) &&
                    $urandom_range(0, 3) == 0) begin
                    stall_left = pick_gap();
                    if (stall_left > longest_hold) longest_hold = stall_left;
                end
            end
        end
    end

    // ---------------------------------------------------------------- watchdog

    // end the run when no word moves on either side for too long
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if (in_if.valid && !in_if.ready && i_rst_n) input_stalls++;
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) break;
        end
        $display("timeout: no word moved for %0d cycles, %0d still expected",
                 IDLE_LIMIT, ordered_q.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule

[sim.f]
rtl/core/qcco_pkg.sv
rtl/core/qcco_if.sv
rtl/core/qcco_angle_pair.sv
rtl/core/quad_corner_clockwise_order.sv
rtl/core/qcco_checker.sv
verif/quad_corner_clockwise_order_test.sv
